// ===== hw/rtl/lgpv_pkg.sv =====
`timescale 1ns / 1ps

package lgpv_pkg;

  // recurrence counter and divisor width: degree is a 5-bit field
  localparam int K_W = 5;

  // signed numerator accumulator, |numerator| < 2^96
  localparam int ACC_W = 98;

  // dividend is |numerator| >> RND_SHIFT: one extra quotient bit serves rounding
  localparam int RND_SHIFT = 23;

  // divider: DIV_CELLS restoring cells per cycle; the dividend is DIV_CELLS * DIV_CYCLES bits
  localparam int DIV_CELLS  = 8;
  localparam int DIV_CYCLES = 10;
  localparam int DVD_W      = DIV_CELLS * DIV_CYCLES;

  // accumulator alignment of a partial product
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;
  localparam logic [1:0] SH_56 = 2'd3;

  typedef struct packed {
    logic       clear;
    logic       issue;
    logic       neg;
    logic [1:0] shift;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/lgpv_cell.sv =====
`timescale 1ns / 1ps

// One restoring division step: shift in a dividend bit, subtract if it fits.
module lgpv_cell (
  input  logic [lgpv_pkg::K_W-1:0] rem_in,
  input  logic                     bit_in,
  input  logic [lgpv_pkg::K_W-1:0] divisor,
  output logic [lgpv_pkg::K_W-1:0] rem_out,
  output logic                     q_bit
);

  logic [lgpv_pkg::K_W:0] cur;
  logic [lgpv_pkg::K_W:0] diff;

  assign cur     = {rem_in, bit_in};
  assign diff    = cur - {1'b0, divisor};
  assign q_bit   = (cur >= {1'b0, divisor});
  assign rem_out = q_bit ? diff[lgpv_pkg::K_W-1:0] : cur[lgpv_pkg::K_W-1:0];

endmodule

// ===== hw/rtl/lgpv_div.sv =====
`timescale 1ns / 1ps

// Divides a wide unsigned dividend by a small divisor. A row of restoring
// cells retires DIV_CELLS quotient bits per cycle while busy, remainder handed cell to cell.
module lgpv_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lgpv_pkg::DVD_W-1:0]   dividend,
  input  logic [lgpv_pkg::K_W-1:0]     divisor,
  output logic [lgpv_pkg::DVD_W-1:0]   quotient,
  output lgpv_pkg::div_stat_t          stat
);

  localparam int CNT_W = $clog2(lgpv_pkg::DIV_CYCLES);
  localparam int NC    = lgpv_pkg::DIV_CELLS;
  localparam int DW    = lgpv_pkg::DVD_W;

  logic [DW-1:0]                      dvd_r;
  logic [DW-1:0]                      quo_r;
  logic [lgpv_pkg::K_W-1:0]           rem_r;
  logic [lgpv_pkg::K_W-1:0]           dsor_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic                               busy_r;
  logic                               done_r;
  logic [NC:0][lgpv_pkg::K_W-1:0]     rem_chain;
  logic [NC-1:0]                      qbits;

  assign rem_chain[0] = rem_r;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    lgpv_cell u_cell (
      .rem_in  (rem_chain[i]),
      .bit_in  (dvd_r[DW-1-i]),
      .divisor (dsor_r),
      .rem_out (rem_chain[i+1]),
      .q_bit   (qbits[NC-1-i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(lgpv_pkg::DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsor_r <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << NC;
      quo_r <= {quo_r[DW-NC-1:0], qbits};
      rem_r <= rem_chain[NC];
    end
  end

  assign quotient = quo_r;
  assign stat     = {busy_r, done_r};

endmodule

// ===== hw/rtl/lgpv_mac.sv =====
`timescale 1ns / 1ps

// 32x32 multiplier, registered, then a signed shift-and-add into the
// numerator accumulator.
module lgpv_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lgpv_pkg::mac_ctl_t          ctl,
  input  logic [31:0]                 op_a,
  input  logic [31:0]                 op_b,
  output logic [lgpv_pkg::ACC_W-1:0]  acc
);

  localparam int AW = lgpv_pkg::ACC_W;

  logic [63:0]   prod_r;
  logic          pv_r;
  logic          neg_r;
  logic [1:0]    shift_r;
  logic [AW-1:0] acc_r;
  logic [AW-1:0] ext;
  logic [AW-1:0] aligned;
  logic [AW-1:0] addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= op_a * op_b;
    neg_r   <= ctl.neg;
    shift_r <= ctl.shift;
  end

  assign ext = AW'(prod_r);

  always_comb begin
    case (shift_r)
      lgpv_pkg::SH_0:  aligned = ext;
      lgpv_pkg::SH_24: aligned = ext << 24;
      lgpv_pkg::SH_32: aligned = ext << 32;
      lgpv_pkg::SH_56: aligned = ext << 56;
      default:         aligned = ext;
    endcase
  end

  assign addend = neg_r ? (~aligned + AW'(1)) : aligned;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/laguerre_poly_value_gradient.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   in_tdata: point[31:0], degree[36:32]
// out_     out  out_tvalid/out_tready out_tdata: poly_value, poly_slope; out_tuser: saturated
//
// Degree 0 or 1: the item goes straight to ST_DONE and the result register loads
// from there. Degree n >= 2: each of the n-1 recurrence steps runs 10 products
// through the shared 32x32 multiplier and two passes of the divider cell row,
// with control states between them.
// One item at a time; the next item is taken while the result waits in the output
// register; a full output register stalls the block. Sync rst_n clears control only.
module laguerre_poly_value_gradient #(
  parameter int MAX_ORDER = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // point[31:0], degree[36:32], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // poly_value[63:0], poly_slope[127:64]
  output logic [0:0]   out_tuser   // saturated[0]
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam int KW = lgpv_pkg::K_W;
  localparam int AW = lgpv_pkg::ACC_W;
  localparam int DW = lgpv_pkg::DVD_W;

  localparam logic [63:0] ONE_Q     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] NEG_ONE_Q = 64'hFFFF_FFFF_0000_0000;
  localparam logic [63:0] POS_LIM   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM   = 64'h8000_0000_0000_0000;

  logic [2:0]    state_r, state_nxt;
  logic [31:0]   x_r;
  logic [KW-1:0] deg_r;
  logic [KW-1:0] k_r;
  logic [63:0]   lc_r, lp_r, sc_r, sp_r, lnew_r;
  logic          sat_r;
  logic          phase_r;
  logic [2:0]    term_r;
  logic          neg_r;
  logic          out_valid_r;
  logic [127:0]  out_data_r;
  logic          out_sat_r;

  logic          in_acc;
  logic [KW-1:0] in_deg;
  logic [KW-1:0] eff_deg;
  logic [31:0]   coef;
  logic          c_neg;
  logic [31:0]   c_mag;
  logic [63:0]   lc_mag, lp_mag, sc_mag, sp_mag;
  logic [63:0]   src;
  logic [2:0]    last_term;
  logic          out_load;

  lgpv_pkg::mac_ctl_t  mac_ctl;
  logic [31:0]         mac_a;
  logic [AW-1:0]       acc;
  logic [AW-1:0]       acc_mag;

  logic                div_start;
  logic [DW-1:0]       div_q;
  lgpv_pkg::div_stat_t div_st;

  logic [DW:0]   q_rnd;
  logic [DW-1:0] q_half;
  logic [63:0]   limit;
  logic          over;
  logic [63:0]   q_mag;
  logic [63:0]   res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_deg    = in_tdata[36:32];
  assign eff_deg   = ({27'd0, in_deg} > MAX_ORDER) ? KW'(MAX_ORDER) : in_deg;

  // c = (2k+1) - x in Q8.24; |c| < 2^32 always
  assign coef  = {2'b00, k_r, 1'b1, 24'h0};
  assign c_neg = (x_r > coef);
  assign c_mag = c_neg ? (x_r - coef) : (coef - x_r);

  assign lc_mag = lc_r[63] ? (~lc_r + 64'd1) : lc_r;
  assign lp_mag = lp_r[63] ? (~lp_r + 64'd1) : lp_r;
  assign sc_mag = sc_r[63] ? (~sc_r + 64'd1) : sc_r;
  assign sp_mag = sp_r[63] ? (~sp_r + 64'd1) : sp_r;

  // value:  c*Lc - k*Lp<<24           (terms 0..3)
  // slope:  c*Sc - Lc<<24 - k*Sp<<24  (terms 0..5), low half then high half
  always_comb begin
    mac_a         = c_mag;
    src           = lc_mag;
    mac_ctl.clear = (state_r == ST_START) || in_acc;
    mac_ctl.issue = (state_r == ST_MUL);
    mac_ctl.neg   = c_neg ^ lc_r[63];
    case (term_r[2:1])
      2'd0: begin
        mac_a       = c_mag;
        src         = phase_r ? sc_mag : lc_mag;
        mac_ctl.neg = c_neg ^ (phase_r ? sc_r[63] : lc_r[63]);
      end
      2'd1: begin
        mac_a       = phase_r ? 32'd1 : {{(32-KW){1'b0}}, k_r};
        src         = phase_r ? lc_mag : lp_mag;
        mac_ctl.neg = phase_r ? ~lc_r[63] : ~lp_r[63];
      end
      2'd2: begin
        mac_a       = {{(32-KW){1'b0}}, k_r};
        src         = sp_mag;
        mac_ctl.neg = ~sp_r[63];
      end
      default: begin
        mac_a       = c_mag;
        src         = lc_mag;
        mac_ctl.neg = c_neg ^ lc_r[63];
      end
    endcase
    if (term_r[2:1] == 2'd0) begin
      mac_ctl.shift = term_r[0] ? lgpv_pkg::SH_32 : lgpv_pkg::SH_0;
    end else begin
      mac_ctl.shift = term_r[0] ? lgpv_pkg::SH_56 : lgpv_pkg::SH_24;
    end
  end

  assign last_term = phase_r ? 3'd5 : 3'd3;

  lgpv_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (term_r[0] ? src[63:32] : src[31:0]),
    .acc   (acc)
  );

  assign acc_mag   = acc[AW-1] ? (~acc + AW'(1)) : acc;
  assign div_start = (state_r == ST_START);

  lgpv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DW'(acc_mag[AW-1:lgpv_pkg::RND_SHIFT])),
    .divisor  (k_r + KW'(1)),
    .quotient (div_q),
    .stat     (div_st)
  );

  // quotient carries one extra fraction bit: add one and drop it to round
  // half away from zero, then clip to the signed 64-bit range
  assign q_rnd  = {1'b0, div_q} + (DW + 1)'(1);
  assign q_half = q_rnd[DW:1];
  assign limit  = neg_r ? NEG_LIM : POS_LIM;
  assign over   = (|q_half[DW-1:64]) || (q_half[63:0] > limit);
  assign q_mag  = over ? limit : q_half[63:0];
  assign res    = neg_r ? (~q_mag + 64'd1) : q_mag;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = (eff_deg < KW'(2)) ? ST_DONE : ST_MUL;
      ST_MUL:   if (term_r == last_term) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_st.done) state_nxt = ST_FIN;
      ST_FIN: begin
        if (phase_r && (k_r == deg_r - KW'(1))) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_r     <= in_tdata[31:0];
          deg_r   <= eff_deg;
          k_r     <= KW'(1);
          phase_r <= 1'b0;
          term_r  <= 3'd0;
          sat_r   <= 1'b0;
          lp_r    <= ONE_Q;
          sp_r    <= 64'd0;
          if (eff_deg == '0) begin
            lc_r <= ONE_Q;
            sc_r <= 64'd0;
          end else begin
            lc_r <= ONE_Q - {24'd0, in_tdata[31:0], 8'd0};
            sc_r <= NEG_ONE_Q;
          end
        end
      end
      ST_MUL:   term_r <= term_r + 3'd1;
      ST_START: neg_r  <= acc[AW-1];
      ST_FIN: begin
        sat_r  <= sat_r | over;
        term_r <= 3'd0;
        if (!phase_r) begin
          lnew_r  <= res;
          phase_r <= 1'b1;
        end else begin
          lp_r    <= lc_r;
          lc_r    <= lnew_r;
          sp_r    <= sc_r;
          sc_r    <= res;
          k_r     <= k_r + KW'(1);
          phase_r <= 1'b0;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_r <= {sc_r, lc_r};
          out_sat_r  <= sat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (k_r != '0) && (k_r < deg_r))
    else $error("recurrence index out of range");

  a_short_degree: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (eff_deg < KW'(2))) |=> (state_r == ST_DONE))
    else $error("degree 0/1 item did not bypass the recurrence");

  a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> $past(div_st.done))
    else $error("result taken before quotient was ready");

endmodule
